@@ rtl/mpq_pkg.sv @@
package mpq_pkg;

    // Operation codes carried on the input tuser
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_PUSH = 2'd1,
        OP_PEEK = 2'd2,
        OP_POP  = 2'd3
    } t_op;

    localparam int TAG_W   = 32;
    localparam int ROLL_W  = 16;
    localparam int MARKS_W = 10;
    localparam int REC_W   = TAG_W + ROLL_W + MARKS_W;
    localparam int TDATA_W = ((REC_W + 7) / 8) * 8;

    // One record, tag in the lowest bits
    typedef struct packed {
        logic [MARKS_W-1:0] marks;
        logic [ROLL_W-1:0]  roll;
        logic [TAG_W-1:0]   tag;
    } t_rec;

    // Decoded command passed from the front to the back
    typedef struct packed {
        logic ins;
        logic rmv;
        logic rpt;
        t_rec rec;
    } t_cmd;

    // True when record x must stand strictly above record y
    function automatic logic outranks(input t_rec x, input t_rec y);
        logic res;
        if (x.marks != y.marks) begin
            res = (x.marks > y.marks);
        end else begin
            res = (x.roll < y.roll);
        end
        return res;
    endfunction

endpackage

@@ rtl/mpq_front.sv @@
module mpq_front
    import mpq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [TDATA_W-1:0] i_data,
    input  logic [1:0]         i_user,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output t_cmd               o_cmd
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    t_cmd             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    t_op  w_op;
    t_cmd w_cmd;
    logic w_push;
    logic w_pop;

    // Classify the incoming beat
    always_comb begin
        w_op      = t_op'(i_user);
        w_cmd.rec = t_rec'(i_data[REC_W-1:0]);
        w_cmd.ins = (w_op == OP_LOAD) || (w_op == OP_PUSH);
        w_cmd.rmv = (w_op == OP_POP);
        w_cmd.rpt = (w_op != OP_LOAD);
    end

    assign o_ready     = (r_cnt != CNT_W'(QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rptr];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    // Store decoded commands
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/mpq_back.sv @@
module mpq_back
    import mpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  t_cmd               i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [TDATA_W-1:0] o_data,
    output logic [1:0]         o_user
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    t_rec             r_ent [CAPACITY];
    t_rec             n_ent [CAPACITY];
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;
    logic             r_pend;
    logic             r_pend_ovf;
    logic             r_out_valid;
    logic [TDATA_W-1:0] r_out_data;
    logic [1:0]       r_out_user;

    logic [CAPACITY-1:0] w_below;
    logic                w_full;
    logic                w_empty;
    logic                w_out_free;
    logic                w_load_out;
    logic                w_go;
    logic                w_ins_go;
    logic                w_rmv_go;

    assign w_full       = (r_occ == OCC_W'(CAPACITY));
    assign w_empty      = (r_occ == '0);
    assign w_out_free   = !r_out_valid || i_ready;
    assign w_load_out   = r_pend && w_out_free;
    assign o_cmd_ready  = !r_pend || w_out_free;
    assign w_go         = i_cmd_valid && o_cmd_ready;
    assign w_ins_go     = w_go && i_cmd.ins && !w_full;
    assign w_rmv_go     = w_go && i_cmd.rmv && !w_empty;

    // Each cell flags whether the new record settles below it
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_below[i] = (OCC_W'(i) < r_occ) && !outranks(i_cmd.rec, r_ent[i]);
        end
    end

    // Shift the sorted chain for insert or removal
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_ent[i] = r_ent[i];
        end
        n_occ = r_occ;
        if (w_ins_go) begin
            if (!w_below[0]) begin
                n_ent[0] = i_cmd.rec;
            end
            for (int i = 1; i < CAPACITY; i++) begin
                if (!w_below[i]) begin
                    n_ent[i] = w_below[i-1] ? i_cmd.rec : r_ent[i-1];
                end
            end
            n_occ = r_occ + OCC_W'(1);
        end else if (w_rmv_go) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                n_ent[i] = r_ent[i+1];
            end
            n_occ = r_occ - OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_ent[i] <= n_ent[i];
        end
    end

    // Track occupancy, pending report and the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_occ <= n_occ;
            if (w_go) begin
                r_pend <= i_cmd.rpt;
            end else if (w_load_out) begin
                r_pend <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture overflow with the command; report the top once the output register is free
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_pend_ovf <= i_cmd.ins && i_cmd.rpt && w_full;
        end
        if (w_load_out) begin
            r_out_data <= w_empty ? '0 : TDATA_W'(r_ent[0]);
            r_out_user <= {r_pend_ovf, w_empty};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_user  = r_out_user;

endmodule

@@ rtl/max_priority_queue_records.sv @@
// A result beat passes from the command buffer through the sorted chain to
// the output register before it is presented.
// Throughput: up to one item per cycle while the result output is not stalled;
// each insert or removal on the sorted register chain is decided with every cell comparing in parallel.
// Load items produce no result beat; a stalled result beat holds the chain.
// Reset (i_rst_n low, synchronous) empties the queue and the command buffer;
// the block accepts items once reset is released.
module max_priority_queue_records
    import mpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,  // tag[31:0], roll[47:32], marks[57:48], zero pad
    input  logic [1:0]         s_axis_tuser,  // op[1:0]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,  // top_tag[31:0], top_roll[47:32], top_marks[57:48]
    output logic [1:0]         m_axis_tuser   // empty_res[0], overflow[1]
);

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_ready;

    // Accept and decode beats into the command buffer
    mpq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_user      (s_axis_tuser),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    // Execute commands on the sorted chain and report the top
    mpq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_user      (m_axis_tuser)
    );

endmodule
